FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/kfm_pkg.sv
// Shared types and constants of the KMP first-match search block.
`default_nettype none

package kfm_pkg;

	localparam int KFM_PATTERN_MAX = 1024;
	localparam longint unsigned KFM_TEXT_MAX = 64'd1048576;
	localparam int KFM_SYM_W = 8;
	localparam int KFM_STATUS_W = 2;
	localparam int KFM_POS_W = 20;
	localparam int KFM_QUEUE_DEPTH = 4;

	localparam logic MODE_PATTERN = 1'b0;
	localparam logic MODE_TEXT = 1'b1;

	// Result status codes
	typedef enum logic [KFM_STATUS_W-1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_PAT_LONG  = 2'd2,
		ST_TEXT_LONG = 2'd3
	} status_t;

	// Request classes produced by the front end
	typedef enum logic [1:0] {
		CMD_PAT_NEW,
		CMD_PAT_ADD,
		CMD_TXT_NEW,
		CMD_TXT_ADD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  last;
		logic [KFM_SYM_W-1:0]  symbol;
	} kfm_cmd_t;

	typedef enum logic {
		ENG_IDLE,
		ENG_WALK
	} eng_state_t;

	// Engine activity seen by the top level
	typedef struct packed {
		logic taking;
		logic walking;
	} eng_stat_t;

endpackage

`default_nettype wire

FILE: hdl/kmp_first_match_search.sv
// Top level of the KMP first-match search block.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_ready  | mode, symbol, first, last
//  result   | out_valid / out_ready| status, position
//
// A byte needs no compare when it is an ignored text byte or meets an empty
// or overflowed pattern; else the engine fetches, then compares once if no
// mismatch occurs and once more per failure link followed. The pattern store
// and failure table each have a single read port; it sets the compare rate.
// Reset clears all control state; pattern store and failure table need no clearing.
// A front register and a 4-entry queue keep taking requests while a result
// waits; the engine takes no request while an untaken result is held.
`default_nettype none

`include "assert_macros.svh"

module kmp_first_match_search #(
	parameter int              PATTERN_MAX = kfm_pkg::KFM_PATTERN_MAX,
	parameter longint unsigned TEXT_MAX    = kfm_pkg::KFM_TEXT_MAX
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             mode,
	input  wire logic [kfm_pkg::KFM_SYM_W-1:0]    symbol,
	input  wire logic                             first,
	input  wire logic                             last,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [kfm_pkg::KFM_STATUS_W-1:0]      status,
	output logic [kfm_pkg::KFM_POS_W-1:0]         position
);
	import kfm_pkg::*;

	logic                                   push_valid;
	logic                                   push_ready;
	kfm_cmd_t                               push_cmd;
	logic                                   pop_valid;
	logic                                   pop_ready;
	kfm_cmd_t                               pop_cmd;
	logic [$clog2(KFM_QUEUE_DEPTH+1)-1:0]   q_level;
	eng_stat_t                              eng_stat;

	kfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.symbol     (symbol),
		.first      (first),
		.last       (last),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	kfm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.level      (q_level)
	);

	kfm_engine #(
		.PATTERN_MAX (PATTERN_MAX),
		.TEXT_MAX    (TEXT_MAX)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.position   (position),
		.stat       (eng_stat)
	);

	// A request pushed into the queue is held there on the next cycle
	`ASSERT_NEXT(a_push_held, clk, arst_n, push_valid && push_ready, q_level != '0, "queue lost a request")
	// The engine never takes a request while a result is stuck on the output
	`ASSERT_IMPLY(a_no_take_on_stall, clk, arst_n, out_valid && !out_ready, !eng_stat.taking, "request taken while result pending")
	// A result appears only after the engine took or worked on a request
	`ASSERT_NEXT(a_result_sourced, clk, arst_n, !out_valid && !eng_stat.taking && !eng_stat.walking, !out_valid, "result without a request")

endmodule

`default_nettype wire

FILE: hdl/kfm_front.sv
// Front end: takes input requests and classifies them into engine commands.
`default_nettype none

module kfm_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          mode,
	input  wire logic [kfm_pkg::KFM_SYM_W-1:0] symbol,
	input  wire logic                          first,
	input  wire logic                          last,
	output logic                               push_valid,
	input  wire logic                          push_ready,
	output kfm_pkg::kfm_cmd_t                  push_cmd
);
	import kfm_pkg::*;

	kfm_cmd_t cmd_c;
	kfm_cmd_t cmd_s1;
	logic     valid_s1;

	// Classify: pattern or text, new or continued; last only matters for text
	always_comb begin
		cmd_c.symbol = symbol;
		cmd_c.last = (mode == MODE_TEXT) && last;
		if (mode == MODE_TEXT) begin
			cmd_c.kind = first ? CMD_TXT_NEW : CMD_TXT_ADD;
		end else begin
			cmd_c.kind = first ? CMD_PAT_NEW : CMD_PAT_ADD;
		end
	end

	assign in_ready = !valid_s1 || push_ready;

	// Holding stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_c;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd = cmd_s1;

endmodule

`default_nettype wire

FILE: hdl/kfm_queue.sv
// Short command queue between the front end and the engine.
`default_nettype none

module kfm_queue (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        push_valid,
	output logic                                             push_ready,
	input  wire kfm_pkg::kfm_cmd_t                           push_cmd,
	output logic                                             pop_valid,
	input  wire logic                                        pop_ready,
	output kfm_pkg::kfm_cmd_t                                pop_cmd,
	output logic [$clog2(kfm_pkg::KFM_QUEUE_DEPTH+1)-1:0]    level
);
	import kfm_pkg::*;

	localparam int PW = (KFM_QUEUE_DEPTH > 1) ? $clog2(KFM_QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(KFM_QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(KFM_QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] LVL_FULL = CW'(KFM_QUEUE_DEPTH);

	kfm_cmd_t        entries_q [KFM_QUEUE_DEPTH];
	logic [PW-1:0]   head_q;
	logic [PW-1:0]   tail_q;
	logic [CW-1:0]   level_q;
	logic            push_fire;
	logic            pop_fire;

	assign push_ready = (level_q != LVL_FULL);
	assign pop_valid = (level_q != '0);
	assign pop_cmd = entries_q[head_q];
	assign level = level_q;
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			level_q <= '0;
		end else begin
			if (push_fire) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
			end
			if (pop_fire) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
			end
			unique case ({push_fire, pop_fire})
				2'b10: level_q <= level_q + CW'(1);
				2'b01: level_q <= level_q - CW'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_fire) begin
			entries_q[tail_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/kfm_engine.sv
// Back end: pattern store, failure table, and the KMP match engine.
`default_nettype none

module kfm_engine #(
	parameter int              PATTERN_MAX = kfm_pkg::KFM_PATTERN_MAX,
	parameter longint unsigned TEXT_MAX    = kfm_pkg::KFM_TEXT_MAX
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pop_valid,
	output logic                                  pop_ready,
	input  wire kfm_pkg::kfm_cmd_t                pop_cmd,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [kfm_pkg::KFM_STATUS_W-1:0]      status,
	output logic [kfm_pkg::KFM_POS_W-1:0]         position,
	output kfm_pkg::eng_stat_t                    stat
);
	import kfm_pkg::*;

	localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int TPW = $clog2(TEXT_MAX + 1);
	localparam logic [LW-1:0] LEN_FULL = LW'(PATTERN_MAX);
	localparam logic [TPW-1:0] POS_SAT = TPW'(TEXT_MAX);

	// Memories
	logic [KFM_SYM_W-1:0] pattern_mem [PATTERN_MAX];
	logic [AW-1:0]        fail_mem [PATTERN_MAX];
	logic [KFM_SYM_W-1:0] ps_rd_q;
	logic [AW-1:0]        ft_rd_q;
	logic                 ps_we;
	logic [AW-1:0]        ps_waddr;
	logic [AW-1:0]        ps_raddr;
	logic                 ft_we;
	logic [AW-1:0]        ft_waddr;
	logic [AW-1:0]        ft_wdata;
	logic [AW-1:0]        ft_raddr;

	// Control state
	eng_state_t           state_q, state_d;
	logic [LW-1:0]        len_q, len_d;
	logic                 povf_q, povf_d;
	logic [LW-1:0]        mp_q, mp_d;
	logic [TPW-1:0]       pos_q, pos_d;
	logic                 tovf_q, tovf_d;
	logic                 done_q, done_d;
	logic [AW-1:0]        last_fail_q, last_fail_d;
	logic                 out_valid_q, out_valid_d;

	// Working and payload registers
	logic [AW-1:0]        k_q, k_d;
	logic [KFM_SYM_W-1:0] cur_sym_q;
	logic                 cur_last_q;
	logic                 cur_text_q;
	logic [KFM_POS_W-1:0] found_pos_q, found_pos_d;
	status_t              status_q, status_d;
	logic [KFM_POS_W-1:0] position_q, position_d;

	// Combinational helpers
	logic                 take;
	logic                 start_walk;
	logic                 hit;
	logic                 mis;
	logic [LW-1:0]        kf;
	logic                 is_new;
	logic [LW-1:0]        eff_len;
	logic                 eff_povf;
	logic [LW-1:0]        eff_mp;
	logic [TPW-1:0]       eff_pos;
	logic                 eff_tovf;
	logic                 eff_done;
	logic                 tovf_now;

	assign pop_ready = (state_q == ENG_IDLE) && (!out_valid_q || out_ready);
	assign take = pop_ready && pop_valid;

	// Compare of the fetched pattern byte against the current symbol
	assign hit = (ps_rd_q == cur_sym_q);
	assign mis = (k_q != '0) && !hit;
	assign kf = LW'(k_q) + LW'(hit);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (take && start_walk) begin
					state_d = ENG_WALK;
				end
			end
			ENG_WALK: begin
				if (!mis) begin
					state_d = ENG_IDLE;
				end
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	// Datapath and outputs
	always_comb begin
		len_d = len_q;
		povf_d = povf_q;
		mp_d = mp_q;
		pos_d = pos_q;
		tovf_d = tovf_q;
		done_d = done_q;
		last_fail_d = last_fail_q;
		k_d = k_q;
		found_pos_d = found_pos_q;
		out_valid_d = out_valid_q && !out_ready;
		status_d = status_q;
		position_d = position_q;
		start_walk = 1'b0;
		ps_we = 1'b0;
		ps_waddr = '0;
		ps_raddr = k_q;
		ft_we = 1'b0;
		ft_waddr = '0;
		ft_wdata = '0;
		ft_raddr = k_q - AW'(1);
		is_new = (pop_cmd.kind == CMD_PAT_NEW) || (pop_cmd.kind == CMD_TXT_NEW);
		eff_len = is_new ? '0 : len_q;
		eff_povf = is_new ? 1'b0 : povf_q;
		eff_mp = is_new ? '0 : mp_q;
		eff_pos = is_new ? '0 : pos_q;
		eff_tovf = is_new ? 1'b0 : tovf_q;
		eff_done = is_new ? 1'b0 : done_q;
		tovf_now = eff_tovf || (eff_pos == POS_SAT);

		unique case (state_q)
			ENG_IDLE: begin
				if (take) begin
					unique case (pop_cmd.kind)
						CMD_PAT_NEW, CMD_PAT_ADD: begin
							// Pattern byte: ends any text, stores and builds its entry unless full
							done_d = 1'b1;
							mp_d = '0;
							povf_d = eff_povf;
							len_d = eff_len;
							if (eff_len == LEN_FULL) begin
								povf_d = 1'b1;
							end else begin
								ps_we = 1'b1;
								ps_waddr = eff_len[AW-1:0];
								if (eff_len == '0) begin
									ft_we = 1'b1;
									ft_waddr = '0;
									ft_wdata = '0;
									last_fail_d = '0;
									len_d = eff_len + LW'(1);
								end else begin
									start_walk = 1'b1;
									k_d = last_fail_q;
									ps_raddr = last_fail_q;
									ft_raddr = last_fail_q - AW'(1);
								end
							end
						end
						CMD_TXT_NEW, CMD_TXT_ADD: begin
							mp_d = eff_mp;
							pos_d = eff_pos;
							tovf_d = eff_tovf;
							done_d = eff_done;
							if (!eff_done) begin
								if (eff_pos != POS_SAT) begin
									pos_d = eff_pos + TPW'(1);
								end
								if (povf_q) begin
									if (pop_cmd.last) begin
										out_valid_d = 1'b1;
										status_d = ST_PAT_LONG;
										position_d = '0;
										done_d = 1'b1;
									end
								end else if (len_q == '0) begin
									// Empty pattern matches at once
									out_valid_d = 1'b1;
									status_d = ST_FOUND;
									position_d = '0;
									done_d = 1'b1;
								end else begin
									tovf_d = tovf_now;
									if (!tovf_now) begin
										start_walk = 1'b1;
										k_d = eff_mp[AW-1:0];
										ps_raddr = eff_mp[AW-1:0];
										ft_raddr = eff_mp[AW-1:0] - AW'(1);
										found_pos_d = KFM_POS_W'(eff_pos) + KFM_POS_W'(1)
											- KFM_POS_W'(len_q);
									end else if (pop_cmd.last) begin
										out_valid_d = 1'b1;
										status_d = ST_TEXT_LONG;
										position_d = '0;
										done_d = 1'b1;
									end
								end
							end
						end
					endcase
				end
			end
			ENG_WALK: begin
				if (mis) begin
					// Follow the failure chain one link
					k_d = ft_rd_q;
					ps_raddr = ft_rd_q;
					ft_raddr = ft_rd_q - AW'(1);
				end else if (cur_text_q) begin
					mp_d = kf;
					if (kf == len_q) begin
						out_valid_d = 1'b1;
						status_d = ST_FOUND;
						position_d = found_pos_q;
						done_d = 1'b1;
					end else if (cur_last_q) begin
						out_valid_d = 1'b1;
						status_d = ST_NOT_FOUND;
						position_d = '0;
						done_d = 1'b1;
					end
				end else begin
					// New failure entry for the pattern byte just stored
					ft_we = 1'b1;
					ft_waddr = len_q[AW-1:0];
					ft_wdata = kf[AW-1:0];
					last_fail_d = kf[AW-1:0];
					len_d = len_q + LW'(1);
				end
			end
			default: begin
				out_valid_d = out_valid_q && !out_ready;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			len_q <= '0;
			povf_q <= 1'b0;
			mp_q <= '0;
			pos_q <= '0;
			tovf_q <= 1'b0;
			done_q <= 1'b0;
			last_fail_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q <= len_d;
			povf_q <= povf_d;
			mp_q <= mp_d;
			pos_q <= pos_d;
			tovf_q <= tovf_d;
			done_q <= done_d;
			last_fail_q <= last_fail_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		k_q <= k_d;
		found_pos_q <= found_pos_d;
		status_q <= status_d;
		position_q <= position_d;
		if (take) begin
			cur_sym_q <= pop_cmd.symbol;
			cur_last_q <= pop_cmd.last;
			cur_text_q <= (pop_cmd.kind == CMD_TXT_NEW) || (pop_cmd.kind == CMD_TXT_ADD);
		end
	end

	// Pattern store
	always_ff @(posedge clk) begin
		if (ps_we) begin
			pattern_mem[ps_waddr] <= pop_cmd.symbol;
		end
		ps_rd_q <= pattern_mem[ps_raddr];
	end

	// Failure table
	always_ff @(posedge clk) begin
		if (ft_we) begin
			fail_mem[ft_waddr] <= ft_wdata;
		end
		ft_rd_q <= fail_mem[ft_raddr];
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign position = position_q;
	assign stat.taking = take;
	assign stat.walking = (state_q == ENG_WALK);

endmodule

`default_nettype wire
